// ===== rtl/core/bounded_ordered_list_engine_top_macros.svh =====
// Assertion macros for the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define BOLE_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define BOLE_CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/bole_pkg.sv =====
// Package of the ordered list engine: sizes, types, codes and control structs.
package bole_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    typedef logic signed [VAL_W-1:0] t_word;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [POS_W-1:0]        t_pos;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT  = 3'd0,
        OP_INS_BACK   = 3'd1,
        OP_INS_SORTED = 3'd2,
        OP_DEL_FIRST  = 3'd3,
        OP_DEL_LAST   = 3'd4,
        OP_DEL_AT     = 3'd5,
        OP_SORT       = 3'd6,
        OP_DUMP       = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        C_HOLD,
        C_INS_FRONT,
        C_INS_BACK,
        C_CMP,
        C_INS_SORTED,
        C_DEL_AT,
        C_SORT_EVEN,
        C_SORT_ODD,
        C_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_word    value;
        t_pos     pos;
        t_cnt     count;
    } t_cell_ctl;

    typedef struct packed {
        t_word   entry_value;
        t_cnt    entry_count;
        t_status status;
        logic    last_result;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INSS,
        S_SORT,
        S_DUMP
    } t_state;

endpackage

// ===== rtl/core/bole_ifs.sv =====
// Request and result channel interfaces of the ordered list engine.
interface bole_in_if;
    logic              valid;
    logic              ready;
    bole_pkg::t_op     operation;
    bole_pkg::t_word   value;
    bole_pkg::t_pos    position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface bole_out_if;
    logic              valid;
    logic              ready;
    bole_pkg::t_word   entry_value;
    bole_pkg::t_cnt    entry_count;
    bole_pkg::t_status status;
    logic              last_result;

    modport source (output valid, output entry_value, output entry_count, output status,
                    output last_result, input ready);
    modport sink   (input valid, input entry_value, input entry_count, input status,
                    input last_result, output ready);
endinterface

// ===== rtl/core/bole_cell.sv =====
// One list cell: holds one entry and trades it with its neighbors.
module bole_cell (
    input  logic                i_clk,
    input  bole_pkg::t_cell_ctl i_ctl,
    input  bole_pkg::t_idx      i_idx,
    input  bole_pkg::t_word     i_left,
    input  bole_pkg::t_word     i_right,
    input  logic                i_found,
    output bole_pkg::t_word     o_value,
    output logic                o_found
);

    bole_pkg::t_word r_value;
    bole_pkg::t_word n_value;
    logic            r_ge;
    logic            n_ge;
    bole_pkg::t_cnt  w_idx;
    bole_pkg::t_cnt  w_nxt;
    logic            w_occ;
    logic            w_lo;

    assign w_idx   = bole_pkg::t_cnt'(i_idx);
    assign w_nxt   = w_idx + bole_pkg::t_cnt'(1);
    assign w_occ   = w_idx < i_ctl.count;
    assign w_lo    = i_idx[0] == (i_ctl.op == bole_pkg::C_SORT_ODD);
    assign o_found = i_found | r_ge;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        n_ge    = r_ge;
        case (i_ctl.op)
            bole_pkg::C_INS_FRONT: begin
                n_value = (i_idx == '0) ? i_ctl.value : i_left;
            end
            bole_pkg::C_INS_BACK: begin
                if (w_idx == i_ctl.count) begin
                    n_value = i_ctl.value;
                end
            end
            bole_pkg::C_CMP: begin
                n_ge = !(w_occ && (r_value < i_ctl.value));
            end
            bole_pkg::C_INS_SORTED: begin
                if (i_found) begin
                    n_value = i_left;
                end else if (r_ge) begin
                    n_value = i_ctl.value;
                end
            end
            bole_pkg::C_DEL_AT: begin
                if (bole_pkg::t_pos'(i_idx) >= i_ctl.pos) begin
                    n_value = i_right;
                end
            end
            bole_pkg::C_SORT_EVEN, bole_pkg::C_SORT_ODD: begin
                if (w_lo) begin
                    if ((w_nxt < i_ctl.count) && (i_right < r_value)) begin
                        n_value = i_right;
                    end
                end else if ((i_idx != '0) && w_occ && (r_value < i_left)) begin
                    n_value = i_left;
                end
            end
            bole_pkg::C_ROTATE: begin
                if (w_nxt < i_ctl.count) begin
                    n_value = i_right;
                end else if (w_nxt == i_ctl.count) begin
                    n_value = i_ctl.value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_ge    <= n_ge;
    end

endmodule

// ===== rtl/core/bounded_ordered_list_engine_top.sv =====
// Top level of the ordered list engine: request decode, cell row and result register.
// Keeps up to DEPTH signed entries in a row of cells, one entry per cell, position 0 at the
// front. One request is worked on at a time. Insert front/back and delete first/at are
// accepted, then the whole row shifts once; delete last changes only the count, and any
// dropped or ignored request leaves the row as it is. Insert sorted: every cell compares
// against the value, then the row opens a gap. Sort: accept, decode, then DEPTH alternating
// even/odd passes of neighbor compare-and-swap. Dump: accept, decode, then one entry per
// cycle while the result side takes them, as the row rotates back into place.
// A registered result stage lets the next request enter while a result waits to be taken,
// and a stalled result side holds the row before any step that loads a result.
`include "bounded_ordered_list_engine_top_macros.svh"

module bounded_ordered_list_engine_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bole_in_if.sink    i_req,
    bole_out_if.source o_res
);

    bole_pkg::t_state    r_state;
    bole_pkg::t_state    n_state;
    bole_pkg::t_cnt      r_count;
    bole_pkg::t_cnt      n_count;
    bole_pkg::t_idx      r_step;
    bole_pkg::t_idx      n_step;
    bole_pkg::t_op       r_op;
    bole_pkg::t_word     r_val;
    bole_pkg::t_pos      r_pos;
    logic                r_out_valid;
    bole_pkg::t_result   r_out;
    bole_pkg::t_result   w_res;
    logic                w_load;
    logic                w_free;
    logic                w_full;
    logic                w_empty;
    logic                w_accept;
    bole_pkg::t_cell_ctl w_ctl;
    bole_pkg::t_word     w_head;

    bole_pkg::t_word w_val   [bole_pkg::DEPTH];
    bole_pkg::t_word w_left  [bole_pkg::DEPTH];
    bole_pkg::t_word w_right [bole_pkg::DEPTH];
    logic            w_fin   [bole_pkg::DEPTH];
    logic            w_fout  [bole_pkg::DEPTH];

    assign i_req.ready       = r_state == bole_pkg::S_IDLE;
    assign w_accept          = i_req.valid && i_req.ready;
    assign w_free            = !r_out_valid || o_res.ready;
    assign w_full            = r_count == bole_pkg::t_cnt'(bole_pkg::DEPTH);
    assign w_empty           = r_count == '0;
    assign w_head            = w_val[0];

    assign o_res.valid       = r_out_valid;
    assign o_res.entry_value = r_out.entry_value;
    assign o_res.entry_count = r_out.entry_count;
    assign o_res.status      = r_out.status;
    assign o_res.last_result = r_out.last_result;

    always_comb begin
        for (int i = 0; i < bole_pkg::DEPTH; i++) begin
            w_left[i]  = (i == 0) ? '0 : w_val[(i == 0) ? 0 : i - 1];
            w_right[i] = (i == bole_pkg::DEPTH - 1) ? '0 :
                         w_val[(i == bole_pkg::DEPTH - 1) ? i : i + 1];
            w_fin[i]   = (i == 0) ? 1'b0 : w_fout[(i == 0) ? 0 : i - 1];
        end
    end

    for (genvar g = 0; g < bole_pkg::DEPTH; g++) begin : g_cell
        bole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (bole_pkg::t_idx'(g)),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_found (w_fin[g]),
            .o_value (w_val[g]),
            .o_found (w_fout[g])
        );
    end

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_step            = r_step;
        w_load            = 1'b0;
        w_ctl.op          = bole_pkg::C_HOLD;
        w_ctl.value       = r_val;
        w_ctl.pos         = r_pos;
        w_ctl.count       = r_count;
        w_res.entry_value = '0;
        w_res.status      = bole_pkg::ST_DONE;
        w_res.last_result = 1'b1;
        case (r_state)
            bole_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = bole_pkg::S_EXEC;
                end
            end
            bole_pkg::S_EXEC: begin
                case (r_op)
                    bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK: begin
                        if (w_free) begin
                            w_load  = 1'b1;
                            n_state = bole_pkg::S_IDLE;
                            if (w_full) begin
                                w_res.status = bole_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = (r_op == bole_pkg::OP_INS_FRONT) ?
                                           bole_pkg::C_INS_FRONT : bole_pkg::C_INS_BACK;
                                n_count  = r_count + bole_pkg::t_cnt'(1);
                            end
                        end
                    end
                    bole_pkg::OP_INS_SORTED: begin
                        if (!w_full) begin
                            w_ctl.op = bole_pkg::C_CMP;
                            n_state  = bole_pkg::S_INSS;
                        end else if (w_free) begin
                            w_load       = 1'b1;
                            w_res.status = bole_pkg::ST_FULL;
                            n_state      = bole_pkg::S_IDLE;
                        end
                    end
                    bole_pkg::OP_DEL_FIRST, bole_pkg::OP_DEL_LAST, bole_pkg::OP_DEL_AT: begin
                        if (w_free) begin
                            w_load  = 1'b1;
                            n_state = bole_pkg::S_IDLE;
                            if (w_empty) begin
                                w_res.status = bole_pkg::ST_EMPTY;
                            end else if ((r_op == bole_pkg::OP_DEL_AT) &&
                                         (r_pos >= bole_pkg::t_pos'(r_count))) begin
                                w_res.status = bole_pkg::ST_RANGE;
                            end else begin
                                n_count = r_count - bole_pkg::t_cnt'(1);
                                if (r_op != bole_pkg::OP_DEL_LAST) begin
                                    w_ctl.op  = bole_pkg::C_DEL_AT;
                                    w_ctl.pos = (r_op == bole_pkg::OP_DEL_AT) ? r_pos : '0;
                                end
                            end
                        end
                    end
                    bole_pkg::OP_SORT: begin
                        n_step  = '0;
                        n_state = bole_pkg::S_SORT;
                    end
                    bole_pkg::OP_DUMP: begin
                        n_step = '0;
                        if (!w_empty) begin
                            n_state = bole_pkg::S_DUMP;
                        end else if (w_free) begin
                            w_load       = 1'b1;
                            w_res.status = bole_pkg::ST_EMPTY;
                            n_state      = bole_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = bole_pkg::S_IDLE;
                    end
                endcase
            end
            bole_pkg::S_INSS: begin
                if (w_free) begin
                    w_ctl.op = bole_pkg::C_INS_SORTED;
                    n_count  = r_count + bole_pkg::t_cnt'(1);
                    w_load   = 1'b1;
                    n_state  = bole_pkg::S_IDLE;
                end
            end
            bole_pkg::S_SORT: begin
                if (r_step != bole_pkg::t_idx'(bole_pkg::DEPTH - 1)) begin
                    w_ctl.op = r_step[0] ? bole_pkg::C_SORT_ODD : bole_pkg::C_SORT_EVEN;
                    n_step   = r_step + bole_pkg::t_idx'(1);
                end else if (w_free) begin
                    w_ctl.op = r_step[0] ? bole_pkg::C_SORT_ODD : bole_pkg::C_SORT_EVEN;
                    w_load   = 1'b1;
                    n_state  = bole_pkg::S_IDLE;
                end
            end
            bole_pkg::S_DUMP: begin
                w_res.entry_value = w_head;
                w_res.last_result = (bole_pkg::t_cnt'(r_step) + bole_pkg::t_cnt'(1)) == r_count;
                if (w_free) begin
                    w_ctl.op    = bole_pkg::C_ROTATE;
                    w_ctl.value = w_head;
                    w_load      = 1'b1;
                    n_step      = r_step + bole_pkg::t_idx'(1);
                    if (w_res.last_result) begin
                        n_state = bole_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bole_pkg::S_IDLE;
            end
        endcase
        w_res.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bole_pkg::S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.operation;
            r_val <= i_req.value;
            r_pos <= i_req.position;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    `BOLE_CHK_ALWAYS(a_count_bound, !i_rst_n || (r_count <= bole_pkg::t_cnt'(bole_pkg::DEPTH)), "count above depth")
    `BOLE_CHK(a_count_step, (r_count == $past(r_count)) || (r_count == $past(r_count) + bole_pkg::t_cnt'(1)) || (r_count + bole_pkg::t_cnt'(1) == $past(r_count)), "count moved by more than one")
    `BOLE_CHK(a_full_count, (r_out_valid && (r_out.status == bole_pkg::ST_FULL)) |-> (r_out.entry_count == bole_pkg::t_cnt'(bole_pkg::DEPTH)), "full drop on a list that is not full")
    `BOLE_CHK(a_slot_found, (r_state == bole_pkg::S_INSS) |-> w_fout[bole_pkg::DEPTH - 1], "sorted insert found no slot")

endmodule

// ===== sim/bounded_ordered_list_engine_top_test.sv =====
// Testbench of the ordered list engine: directed and random requests checked against a shadow list.
module bounded_ordered_list_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bole_in_if  req_ch ();
    bole_out_if res_ch ();

    bounded_ordered_list_engine_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    bole_pkg::t_word   list_shadow[$];
    bole_pkg::t_result awaited_results[$];
    int      bad_result_count = 0;
    int      quiet_cycles = 0;
    int      src_idle_pct = 36;
    int      sink_idle_pct = 36;

    always #1ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic flag_bad_result(string msg);
        $display("%0t ERROR %s", $realtime, msg);
        bad_result_count++;
    endtask

    function automatic void apply_list_op(bole_pkg::t_op op, bole_pkg::t_word value,
                                          bole_pkg::t_pos pos);
        bole_pkg::t_result res;
        bole_pkg::t_word   key;
        int      slot;
        res.entry_value = '0;
        res.status      = bole_pkg::ST_DONE;
        res.last_result = 1'b1;
        case (op)
            bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK, bole_pkg::OP_INS_SORTED: begin
                if (list_shadow.size() >= bole_pkg::DEPTH) begin
                    res.status = bole_pkg::ST_FULL;
                end else if (op == bole_pkg::OP_INS_FRONT) begin
                    list_shadow.push_front(value);
                end else if (op == bole_pkg::OP_INS_BACK) begin
                    list_shadow.push_back(value);
                end else begin
                    slot = 0;
                    while (slot < list_shadow.size() && list_shadow[slot] < value) slot++;
                    list_shadow.insert(slot, value);
                end
            end
            bole_pkg::OP_DEL_FIRST: begin
                if (list_shadow.size() == 0) res.status = bole_pkg::ST_EMPTY;
                else void'(list_shadow.pop_front());
            end
            bole_pkg::OP_DEL_LAST: begin
                if (list_shadow.size() == 0) res.status = bole_pkg::ST_EMPTY;
                else void'(list_shadow.pop_back());
            end
            bole_pkg::OP_DEL_AT: begin
                if (list_shadow.size() == 0) res.status = bole_pkg::ST_EMPTY;
                else if (int'(pos) >= list_shadow.size()) res.status = bole_pkg::ST_RANGE;
                else list_shadow.delete(int'(pos));
            end
            bole_pkg::OP_SORT: begin
                for (int i = 1; i < list_shadow.size(); i++) begin
                    key  = list_shadow[i];
                    slot = i;
                    while (slot > 0 && key < list_shadow[slot-1]) begin
                        list_shadow[slot] = list_shadow[slot-1];
                        slot--;
                    end
                    list_shadow[slot] = key;
                end
            end
            default: begin
                res.entry_count = bole_pkg::t_cnt'(list_shadow.size());
                if (list_shadow.size() == 0) begin
                    res.status = bole_pkg::ST_EMPTY;
                    awaited_results.push_back(res);
                end
                for (int i = 0; i < list_shadow.size(); i++) begin
                    res.entry_value = list_shadow[i];
                    res.last_result = (i == list_shadow.size() - 1);
                    awaited_results.push_back(res);
                end
                return;
            end
        endcase
        res.entry_count = bole_pkg::t_cnt'(list_shadow.size());
        awaited_results.push_back(res);
    endfunction

    always @(posedge i_clk) begin
        bole_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                flag_bad_result($sformatf("result with nothing awaited, value %0d",
                                          res_ch.entry_value));
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.entry_value !== want.entry_value)
                    flag_bad_result($sformatf("entry_value %0d, want %0d",
                                              res_ch.entry_value, want.entry_value));
                if (res_ch.entry_count !== want.entry_count)
                    flag_bad_result($sformatf("entry_count %0d, want %0d",
                                              res_ch.entry_count, want.entry_count));
                if (res_ch.status !== want.status)
                    flag_bad_result($sformatf("status %0d, want %0d",
                                              res_ch.status, want.status));
                if (res_ch.last_result !== want.last_result)
                    flag_bad_result($sformatf("last_result %0b, want %0b",
                                              res_ch.last_result, want.last_result));
            end
        end
    end

    task automatic send_request(bole_pkg::t_op op, bole_pkg::t_word value,
                                bole_pkg::t_pos pos);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= value;
        req_ch.position  <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_list_op(op, value, pos);
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic bole_pkg::t_word random_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return bole_pkg::t_word'($urandom_range(8)) - 4;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_mix(int n, int ins_pct);
        int    pick;
        bole_pkg::t_word v;
        bole_pkg::t_pos  p;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            v    = random_value();
            if (list_shadow.size() == 0 || $urandom_range(4) == 0)
                p = bole_pkg::t_pos'($urandom_range(255));
            else
                p = bole_pkg::t_pos'($urandom_range(list_shadow.size() - 1));
            if (pick < ins_pct) send_request(bole_pkg::t_op'($urandom_range(2)), v, p);
            else if (pick < ins_pct + 8) send_request(bole_pkg::OP_SORT, v, p);
            else if (pick < ins_pct + 18) send_request(bole_pkg::OP_DUMP, v, p);
            else send_request(bole_pkg::t_op'($urandom_range(5, 3)), v, p);
        end
    endtask

    task automatic test_empty_list();
        send_request(bole_pkg::OP_DUMP, '0, '0);
        send_request(bole_pkg::OP_DEL_FIRST, '0, '0);
        send_request(bole_pkg::OP_DEL_LAST, '0, '0);
        send_request(bole_pkg::OP_DEL_AT, '0, '0);
        send_request(bole_pkg::OP_DEL_AT, '0, 8'hFF);
        send_request(bole_pkg::OP_SORT, '0, '0);
    endtask

    task automatic test_edge_values();
        send_request(bole_pkg::OP_INS_FRONT, 32'sh7FFF_FFFF, '0);
        send_request(bole_pkg::OP_SORT, '0, '0);
        send_request(bole_pkg::OP_INS_BACK, 32'sh8000_0000, 8'hFF);
        send_request(bole_pkg::OP_INS_SORTED, 32'sh0000_0000, '0);
        send_request(bole_pkg::OP_INS_SORTED, -32'sd1, '0);
        send_request(bole_pkg::OP_INS_SORTED, 32'sh7FFF_FFFF, '0);
        send_request(bole_pkg::OP_INS_FRONT, 32'sh8000_0000, '0);
        send_request(bole_pkg::OP_DUMP, '0, '0);
        send_request(bole_pkg::OP_SORT, '0, '0);
        send_request(bole_pkg::OP_DUMP, '0, '0);
        send_request(bole_pkg::OP_DEL_AT, '0, 8'hFF);
        send_request(bole_pkg::OP_DEL_AT, '0, bole_pkg::t_pos'(list_shadow.size()));
        send_request(bole_pkg::OP_DEL_AT, '0, 8'd2);
        send_request(bole_pkg::OP_DEL_FIRST, '0, '0);
        send_request(bole_pkg::OP_DEL_LAST, '0, '0);
        send_request(bole_pkg::OP_DUMP, '0, '0);
    endtask

    task automatic test_random_mix();
        send_random_mix(120, 40);
    endtask

    task automatic test_full_list();
        while (list_shadow.size() < bole_pkg::DEPTH)
            send_request(bole_pkg::t_op'($urandom_range(2)), random_value(), '0);
        send_request(bole_pkg::OP_INS_FRONT, random_value(), '0);
        send_request(bole_pkg::OP_INS_BACK, random_value(), '0);
        send_request(bole_pkg::OP_INS_SORTED, random_value(), '0);
        send_request(bole_pkg::OP_DUMP, '0, '0);
        wait_drain();
        send_request(bole_pkg::OP_SORT, '0, '0);
        send_request(bole_pkg::OP_DUMP, '0, '0);
        send_request(bole_pkg::OP_DEL_AT, '0, bole_pkg::t_pos'(bole_pkg::DEPTH - 1));
        send_request(bole_pkg::OP_DEL_AT, '0, 8'hFF);
        send_random_mix(60, 65);
    endtask

    task automatic test_delete_heavy();
        send_random_mix(60, 25);
    endtask

    task automatic test_no_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_mix(60, 45);
        wait_drain();
        src_idle_pct  = 36;
        sink_idle_pct = 36;
    endtask

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("bounded_ordered_list_engine_top test failed");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= bole_pkg::OP_INS_FRONT;
        req_ch.value     <= '0;
        req_ch.position  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edge_values();
        test_random_mix();
        test_full_list();
        test_delete_heavy();
        test_no_idle();

        wait_drain();
        repeat (2 * bole_pkg::DEPTH + 8) @(posedge i_clk);
        if (bad_result_count == 0 && awaited_results.size() == 0) begin
            $display("bounded_ordered_list_engine_top test passed");
        end else begin
            $display("bounded_ordered_list_engine_top test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_ifs.sv
rtl/core/bole_cell.sv
rtl/core/bounded_ordered_list_engine_top.sv
sim/bounded_ordered_list_engine_top_test.sv
